// ===== sv/fbf_pkg.sv =====
// Package for the FENE bond force pipeline: payload words, side-band structs
// and fixed-point constants. No dependencies.
package fbf_pkg;

  localparam int POS_W   = 32;
  localparam int MAG_W   = 32;
  localparam int SQ_W    = 48;
  localparam int DLT_W   = 50;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int DEN_W   = 52;
  localparam int NUM_W   = 84;
  localparam int Q_W     = 48;
  localparam int FORCE_W = 48;

  localparam logic [31:0]        STIFF_RESET = 32'd1966080;
  localparam logic [FORCE_W-1:0] FMAX_POS    = 48'h7FFF_FFFF_FFFF;
  localparam logic [FORCE_W-1:0] FMAX_NEG    = 48'h8000_0000_0000;

  typedef struct packed {
    logic signed [31:0] pos0_x;
    logic signed [31:0] pos0_y;
    logic signed [31:0] pos0_z;
    logic signed [31:0] pos1_x;
    logic signed [31:0] pos1_y;
    logic signed [31:0] pos1_z;
    logic [31:0]        sigma0;
    logic [31:0]        sigma1;
    logic [31:0]        energy0;
    logic [31:0]        energy1;
    logic               same_molecule;
    logic               in_home_image;
  } in_t;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic               apply;
    logic               at_limit;
  } out_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  apply;
    logic                  at_limit;
    logic [DLT_W-1:0]      dlt;
  } side_t;

  typedef struct packed {
    logic neg;
    logic apply;
    logic at_limit;
  } tag_t;

endpackage

// ===== sv/fbf_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, carrying a side word.
// Depends on fbf_pkg.
module fbf_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [fbf_pkg::RAD_W-1:0]  in_rad,
  input  fbf_pkg::side_t             in_side,
  output logic                       out_valid,
  output logic [fbf_pkg::ROOT_W-1:0] out_root,
  output fbf_pkg::side_t             out_side
);

  localparam int N = fbf_pkg::ROOT_W;

  logic [N-1:0]   v_r;
  logic [N+1:0]   rem_r  [N];
  logic [N-1:0]   root_r [N];
  logic [2*N-1:0] rad_r  [N];
  fbf_pkg::side_t side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic           v_in;
    logic [N+1:0]   rem_in;
    logic [N-1:0]   root_in;
    logic [2*N-1:0] rad_in;
    fbf_pkg::side_t side_in;
    logic [N+1:0]   rem_sh;
    logic [N+1:0]   trial;
    logic [N+1:0]   rem_nxt;
    logic [N-1:0]   root_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[N-1:0], rad_in[2*N-1:2*N-2]};
      trial  = {root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[N-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= {rad_in[2*N-3:0], 2'b00};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// ===== sv/fbf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit the result width. Depends on fbf_pkg.
module fbf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [fbf_pkg::NUM_W-1:0] in_num,
  input  logic [fbf_pkg::DEN_W-1:0] in_den,
  input  fbf_pkg::tag_t             in_tag,
  output logic                      out_valid,
  output logic [fbf_pkg::Q_W-1:0]   out_q,
  output logic                      out_ovf,
  output fbf_pkg::tag_t             out_tag
);

  localparam int QW = fbf_pkg::Q_W;
  localparam int DW = fbf_pkg::DEN_W;
  localparam int NW = fbf_pkg::NUM_W;
  localparam int XW = DW + QW;

  logic          pv_r;
  logic          povf_r;
  logic [DW-1:0] prem_r;
  logic [QW-1:0] plow_r;
  logic [DW-1:0] pden_r;
  fbf_pkg::tag_t ptag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      povf_r <= XW'(in_num) >= {in_den, {QW{1'b0}}};
      prem_r <= DW'(in_num[NW-1:QW]);
      plow_r <= in_num[QW-1:0];
      pden_r <= in_den;
      ptag_r <= in_tag;
    end
  end

  logic [QW-1:0] v_r;
  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] den_r [QW];
  logic          ovf_r [QW];
  fbf_pkg::tag_t tag_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] q_in;
    logic [DW-1:0] den_in;
    logic          ovf_in;
    fbf_pkg::tag_t tag_in;
    logic [DW:0]   trial;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign v_in   = pv_r;
      assign rem_in = prem_r;
      assign low_in = plow_r;
      assign q_in   = '0;
      assign den_in = pden_r;
      assign ovf_in = povf_r;
      assign tag_in = ptag_r;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
      assign ovf_in = ovf_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    always_comb begin
      trial = {rem_in, low_in[QW-1]};
      if (trial >= {1'b0, den_in}) begin
        rem_nxt = DW'(trial - {1'b0, den_in});
        q_nxt   = {q_in[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        q_nxt   = {q_in[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= {low_in[QW-2:0], 1'b0};
        q_r[k]   <= q_nxt;
        den_r[k] <= den_in;
        ovf_r[k] <= ovf_in;
        tag_r[k] <= tag_in;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_q     = q_r[QW-1];
  assign out_ovf   = ovf_r[QW-1];
  assign out_tag   = tag_r[QW-1];

endmodule

// ===== sv/fene_bond_force.sv =====
// Top level of the FENE bond force pipeline: pair geometry, square root of the
// energy product, spring factor and per-component division. Uses fbf_pkg,
// fbf_isqrt and fbf_div.
//
//   channel  direction  handshake             word
//   in_      input      in_valid / in_stall   fbf_pkg::in_t
//   out_     output     out_valid / out_stall fbf_pkg::out_t
//   cfg_     input      cfg_wr_en             32-bit stiffness
//
// One pair is accepted per cycle while in_stall is low; each pair passes through
// the 32-stage square root and the 49-stage divider.
// Reset clears all valid bits and loads the default stiffness.
// A stalled output word freezes the whole pipeline, and in_stall follows it.
module fene_bond_force (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  fbf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output fbf_pkg::out_t out_data
);

  logic          en;
  logic [31:0]   stiffness_r;
  logic          out_valid_r;
  fbf_pkg::out_t out_data_r;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r <= fbf_pkg::STIFF_RESET;
    end else if (cfg_wr_en) begin
      stiffness_r <= cfg_wr_data;
    end
  end

  // Stage 1: differences, limit length and energy product.
  logic               s1_v_r;
  logic signed [32:0] s1_dr_r [3];
  logic [34:0]        s1_lim_r;
  logic [63:0]        s1_prod_r;
  logic               s1_apply_r;
  logic [32:0]        sig_sum;

  assign sig_sum = 33'(in_data.sigma0) + 33'(in_data.sigma1);

  // Stage 2: magnitudes and partial products of the limit square.
  logic                      s2_v_r;
  logic [fbf_pkg::MAG_W-1:0] s2_mag_r [3];
  logic [2:0]                s2_neg_r;
  logic [33:0]               s2_lhh_r;
  logic [34:0]               s2_lhl_r;
  logic [35:0]               s2_lll_r;
  logic [63:0]               s2_prod_r;
  logic                      s2_apply_r;

  // Stage 3: partial products of the component squares, and the limit square.
  logic                      s3_v_r;
  logic [fbf_pkg::MAG_W-1:0] s3_mag_r [3];
  logic [2:0]                s3_neg_r;
  logic [31:0]               s3_mhh_r [3];
  logic [31:0]               s3_mhl_r [3];
  logic [31:0]               s3_mll_r [3];
  logic [fbf_pkg::DLT_W-1:0] s3_r02_r;
  logic [63:0]               s3_prod_r;
  logic                      s3_apply_r;
  logic [54:0]               lim_low;

  assign lim_low = {s2_lhl_r, 19'b0} + 55'(s2_lll_r);

  // Stage 4: component squares.
  logic                      s4_v_r;
  logic [fbf_pkg::MAG_W-1:0] s4_mag_r [3];
  logic [2:0]                s4_neg_r;
  logic [fbf_pkg::SQ_W-1:0]  s4_sq_r [3];
  logic [fbf_pkg::DLT_W-1:0] s4_r02_r;
  logic [63:0]               s4_prod_r;
  logic                      s4_apply_r;

  // Stage 5: squared length.
  logic                      s5_v_r;
  logic [fbf_pkg::MAG_W-1:0] s5_mag_r [3];
  logic [2:0]                s5_neg_r;
  logic [fbf_pkg::DLT_W-1:0] s5_dr2_r;
  logic [fbf_pkg::DLT_W-1:0] s5_r02_r;
  logic [63:0]               s5_prod_r;
  logic                      s5_apply_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dr_r[0] <= 33'(in_data.pos1_x) - 33'(in_data.pos0_x);
      s1_dr_r[1] <= 33'(in_data.pos1_y) - 33'(in_data.pos0_y);
      s1_dr_r[2] <= 33'(in_data.pos1_z) - 33'(in_data.pos0_z);
      s1_lim_r   <= 35'({sig_sum, 1'b0}) + 35'(sig_sum);
      s1_prod_r  <= 64'(in_data.energy0) * 64'(in_data.energy1);
      s1_apply_r <= in_data.same_molecule & in_data.in_home_image;

      for (int c = 0; c < 3; c++) begin
        s2_mag_r[c] <= fbf_pkg::MAG_W'(s1_dr_r[c][32] ? -s1_dr_r[c] : s1_dr_r[c]);
        s2_neg_r[c] <= s1_dr_r[c][32];
      end
      s2_lhh_r   <= 34'(s1_lim_r[34:18]) * 34'(s1_lim_r[34:18]);
      s2_lhl_r   <= 35'(s1_lim_r[34:18]) * 35'(s1_lim_r[17:0]);
      s2_lll_r   <= 36'(s1_lim_r[17:0]) * 36'(s1_lim_r[17:0]);
      s2_prod_r  <= s1_prod_r;
      s2_apply_r <= s1_apply_r;

      for (int c = 0; c < 3; c++) begin
        s3_mag_r[c] <= s2_mag_r[c];
        s3_mhh_r[c] <= 32'(s2_mag_r[c][31:16]) * 32'(s2_mag_r[c][31:16]);
        s3_mhl_r[c] <= 32'(s2_mag_r[c][31:16]) * 32'(s2_mag_r[c][15:0]);
        s3_mll_r[c] <= 32'(s2_mag_r[c][15:0]) * 32'(s2_mag_r[c][15:0]);
      end
      s3_neg_r   <= s2_neg_r;
      s3_r02_r   <= fbf_pkg::DLT_W'({s2_lhh_r, 16'b0} + 50'(lim_low[54:20]));
      s3_prod_r  <= s2_prod_r;
      s3_apply_r <= s2_apply_r;

      for (int c = 0; c < 3; c++) begin
        s4_mag_r[c] <= s3_mag_r[c];
        s4_sq_r[c]  <= fbf_pkg::SQ_W'({s3_mhh_r[c], 16'b0} + 48'({s3_mhl_r[c], 1'b0})
                                      + 48'(s3_mll_r[c][31:16]));
      end
      s4_neg_r   <= s3_neg_r;
      s4_r02_r   <= s3_r02_r;
      s4_prod_r  <= s3_prod_r;
      s4_apply_r <= s3_apply_r;

      for (int c = 0; c < 3; c++) begin
        s5_mag_r[c] <= s4_mag_r[c];
      end
      s5_neg_r   <= s4_neg_r;
      s5_dr2_r   <= fbf_pkg::DLT_W'(s4_sq_r[0]) + fbf_pkg::DLT_W'(s4_sq_r[1])
                    + fbf_pkg::DLT_W'(s4_sq_r[2]);
      s5_r02_r   <= s4_r02_r;
      s5_prod_r  <= s4_prod_r;
      s5_apply_r <= s4_apply_r;
    end
  end

  fbf_pkg::side_t sq_side;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sq_side.mag[c] = s5_mag_r[c];
    end
    sq_side.neg      = s5_neg_r;
    sq_side.apply    = s5_apply_r;
    sq_side.at_limit = s5_r02_r <= s5_dr2_r;
    sq_side.dlt      = s5_r02_r - s5_dr2_r;
  end

  logic                       rt_v;
  logic [fbf_pkg::ROOT_W-1:0] rt_root;
  fbf_pkg::side_t             rt_side;

  fbf_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_v_r),
    .in_rad    (s5_prod_r),
    .in_side   (sq_side),
    .out_valid (rt_v),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  // Spring factor, its ninefold, the component products and their sums.
  logic                      sa_v_r;
  logic [63:0]               sa_afull_r;
  fbf_pkg::side_t            sa_side_r;
  logic                      sb_v_r;
  logic [fbf_pkg::DEN_W-1:0] sb_a9_r;
  logic [fbf_pkg::DEN_W-1:0] sb_dv_r;
  fbf_pkg::side_t            sb_side_r;
  logic                      sc_v_r;
  logic [57:0]               sc_plo_r [3];
  logic [57:0]               sc_phi_r [3];
  logic [fbf_pkg::DEN_W-1:0] sc_dv_r;
  fbf_pkg::side_t            sc_side_r;
  logic                      sd_v_r;
  logic [fbf_pkg::NUM_W-1:0] sd_num_r [3];
  logic [fbf_pkg::DEN_W-1:0] sd_dv_r;
  fbf_pkg::side_t            sd_side_r;
  logic [47:0]               a_q16;

  assign a_q16 = sa_afull_r[63:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
      sb_v_r <= 1'b0;
      sc_v_r <= 1'b0;
      sd_v_r <= 1'b0;
    end else if (en) begin
      sa_v_r <= rt_v;
      sb_v_r <= sa_v_r;
      sc_v_r <= sb_v_r;
      sd_v_r <= sc_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_afull_r <= 64'(stiffness_r) * 64'(rt_root);
      sa_side_r  <= rt_side;

      sb_a9_r   <= fbf_pkg::DEN_W'({a_q16, 3'b000}) + fbf_pkg::DEN_W'(a_q16);
      sb_dv_r   <= {sa_side_r.dlt, 2'b00};
      sb_side_r <= sa_side_r;

      for (int c = 0; c < 3; c++) begin
        sc_plo_r[c] <= 58'(sb_side_r.mag[c]) * 58'(sb_a9_r[25:0]);
        sc_phi_r[c] <= 58'(sb_side_r.mag[c]) * 58'(sb_a9_r[51:26]);
      end
      sc_dv_r   <= sb_dv_r;
      sc_side_r <= sb_side_r;

      for (int c = 0; c < 3; c++) begin
        sd_num_r[c] <= fbf_pkg::NUM_W'(sc_plo_r[c]) + {sc_phi_r[c], 26'b0};
      end
      sd_dv_r   <= sc_dv_r;
      sd_side_r <= sc_side_r;
    end
  end

  logic [2:0]              dv_v;
  logic [fbf_pkg::Q_W-1:0] dv_q   [3];
  logic [2:0]              dv_ovf;
  fbf_pkg::tag_t           dv_tag [3];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    fbf_pkg::tag_t tag_in;

    assign tag_in.neg      = sd_side_r.neg[c];
    assign tag_in.apply    = sd_side_r.apply;
    assign tag_in.at_limit = sd_side_r.at_limit;

    fbf_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sd_v_r),
      .in_num    (sd_num_r[c]),
      .in_den    (sd_dv_r),
      .in_tag    (tag_in),
      .out_valid (dv_v[c]),
      .out_q     (dv_q[c]),
      .out_ovf   (dv_ovf[c]),
      .out_tag   (dv_tag[c])
    );
  end

  function automatic logic [fbf_pkg::FORCE_W-1:0] force_sel(
    input fbf_pkg::tag_t           tag,
    input logic [fbf_pkg::Q_W-1:0] q,
    input logic                    ovf
  );
    logic [fbf_pkg::FORCE_W-1:0] f;
    if (!tag.apply) begin
      f = '0;
    end else if (tag.at_limit || ovf || q[fbf_pkg::Q_W-1]) begin
      f = tag.neg ? fbf_pkg::FMAX_NEG : fbf_pkg::FMAX_POS;
    end else begin
      f = tag.neg ? -q : q;
    end
    return f;
  endfunction

  fbf_pkg::out_t out_nxt;

  always_comb begin
    out_nxt.force_x  = force_sel(dv_tag[0], dv_q[0], dv_ovf[0]);
    out_nxt.force_y  = force_sel(dv_tag[1], dv_q[1], dv_ovf[1]);
    out_nxt.force_z  = force_sel(dv_tag[2], dv_q[2], dv_ovf[2]);
    out_nxt.apply    = dv_tag[0].apply;
    out_nxt.at_limit = dv_tag[0].apply & dv_tag[0].at_limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_limit_needs_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.at_limit |-> out_data_r.apply)
    else $error("at_limit set on a skipped pair");

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.apply |->
      out_data_r.force_x == '0 && out_data_r.force_y == '0 && out_data_r.force_z == '0)
    else $error("skipped pair carries a force");

  a_limit_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.at_limit |->
      out_data_r.force_x == fbf_pkg::FMAX_POS || out_data_r.force_x == fbf_pkg::FMAX_NEG)
    else $error("limit force is not full scale");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v[0] == dv_v[1] && dv_v[1] == dv_v[2])
    else $error("divider lanes out of step");
`endif

endmodule
